FILE: rtl/core/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared widths, constants and fixed-point helpers for the Euler-to-matrix
// pipeline.
// ----------------------------------------------------------------------------
package e2r_pkg;

    localparam int ANGLE_W = 16;
    localparam int COEF_W  = 16;
    localparam int MOVE_W  = 32;
    localparam int STAGES  = 14;
    localparam int ATAN_N  = 30;

    localparam int ZW = 34;   // CORDIC datapath, Q.30 with headroom
    localparam int VW = 32;   // sine/cosine, quaternion, products (Q.30)
    localparam int TW = 36;   // matrix sums before output rounding
    localparam int OW = TW - (32 - COEF_W);  // after rounding shift

    // fold 1 + CORDIC + sign fix 1 + quaternion 3 + matrix 2
    localparam int LATENCY = STAGES + 7;

    typedef logic signed [ZW-1:0]     zval_t;
    typedef logic signed [VW-1:0]     val_t;
    typedef logic signed [TW-1:0]     tval_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [MOVE_W-1:0] move_t;

    localparam zval_t TWO_PI  = 34'sd6746518852;
    localparam zval_t PI      = 34'sd3373259426;
    localparam zval_t HALF_PI = 34'sd1686629713;
    localparam zval_t GAIN    = 34'sd652032874;

    localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

    // atan(2^-i) in Q.30
    function automatic zval_t atan_q30(input int i);
        zval_t v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            default: v = (i < ATAN_N) ? zval_t'(34'sd1 <<< (30 - i)) : '0;
        endcase
        return v;
    endfunction

    // Q.30 product, round half up
    function automatic val_t mul30(input val_t a, input val_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + HALF_Q30;
        return p[61:30];
    endfunction

    // Q.30 -> output format, rounded and saturated
    function automatic coef_t coef_out(input tval_t t);
        logic signed [OW-1:0] v;
        tval_t r;
        r = t + (tval_t'(1) <<< (32 - COEF_W - 1));
        v = OW'(r >>> (32 - COEF_W));
        if (v > OW'((1 <<< (COEF_W - 1)) - 1))
            return coef_t'((1 <<< (COEF_W - 1)) - 1);
        else if (v < -OW'(1 <<< (COEF_W - 1)))
            return coef_t'(-(1 <<< (COEF_W - 1)));
        return v[COEF_W-1:0];
    endfunction

endpackage

FILE: rtl/core/e2r_cordic.sv
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined half-angle sine/cosine: quadrant fold, one register per CORDIC
// iteration, sign fix-up register.
// ----------------------------------------------------------------------------
module e2r_cordic (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] angle,
    output e2r_pkg::val_t                 sin_o,
    output e2r_pkg::val_t                 cos_o
);

    e2r_pkg::zval_t h, r1, r2;
    logic           neg;

    e2r_pkg::zval_t x_reg [e2r_pkg::STAGES+1];
    e2r_pkg::zval_t y_reg [e2r_pkg::STAGES+1];
    e2r_pkg::zval_t z_reg [e2r_pkg::STAGES+1];
    logic           neg_reg [e2r_pkg::STAGES+1];
    e2r_pkg::val_t  sin_reg, cos_reg;

    // half angle in Q.30: angle * 2^17; magnitude stays below 2*pi
    always_comb begin
        h = e2r_pkg::zval_t'(angle) <<< 17;
        if (h > e2r_pkg::PI)
            r1 = h - e2r_pkg::TWO_PI;
        else if (h < -e2r_pkg::PI)
            r1 = h + e2r_pkg::TWO_PI;
        else
            r1 = h;
        neg = 1'b1;
        if (r1 > e2r_pkg::HALF_PI)
            r2 = r1 - e2r_pkg::PI;
        else if (r1 < -e2r_pkg::HALF_PI)
            r2 = r1 + e2r_pkg::PI;
        else begin
            r2  = r1;
            neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]   <= e2r_pkg::GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= r2;
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 0; i < e2r_pkg::STAGES; i++) begin : g_iter
        e2r_pkg::zval_t dx, dy, atn;
        assign dx  = x_reg[i] >>> i;
        assign dy  = y_reg[i] >>> i;
        assign atn = e2r_pkg::atan_q30(i);
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - atn;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + atn;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (neg_reg[e2r_pkg::STAGES]) begin
                cos_reg <= e2r_pkg::val_t'(-x_reg[e2r_pkg::STAGES]);
                sin_reg <= e2r_pkg::val_t'(-y_reg[e2r_pkg::STAGES]);
            end else begin
                cos_reg <= e2r_pkg::val_t'(x_reg[e2r_pkg::STAGES]);
                sin_reg <= e2r_pkg::val_t'(y_reg[e2r_pkg::STAGES]);
            end
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

FILE: rtl/core/e2r_quat.sv
// ----------------------------------------------------------------------------
// e2r_quat
// Z-Y-X unit quaternion from half-angle sines and cosines, three stages.
// ----------------------------------------------------------------------------
module e2r_quat (
    input  logic          aclk,
    input  logic          ce,
    input  e2r_pkg::val_t sx,
    input  e2r_pkg::val_t cx,
    input  e2r_pkg::val_t sy,
    input  e2r_pkg::val_t cy,
    input  e2r_pkg::val_t sz,
    input  e2r_pkg::val_t cz,
    output e2r_pkg::val_t q_o [4]
);

    e2r_pkg::val_t czcy_reg, szsy_reg, czsy_reg, szcy_reg, sx_reg, cx_reg;
    e2r_pkg::val_t p_reg [8];
    e2r_pkg::val_t q_reg [4];

    always_ff @(posedge aclk) begin
        if (ce) begin
            czcy_reg <= e2r_pkg::mul30(cz, cy);
            szsy_reg <= e2r_pkg::mul30(sz, sy);
            czsy_reg <= e2r_pkg::mul30(cz, sy);
            szcy_reg <= e2r_pkg::mul30(sz, cy);
            sx_reg   <= sx;
            cx_reg   <= cx;

            p_reg[0] <= e2r_pkg::mul30(czcy_reg, cx_reg);
            p_reg[1] <= e2r_pkg::mul30(szsy_reg, sx_reg);
            p_reg[2] <= e2r_pkg::mul30(czcy_reg, sx_reg);
            p_reg[3] <= e2r_pkg::mul30(szsy_reg, cx_reg);
            p_reg[4] <= e2r_pkg::mul30(czsy_reg, cx_reg);
            p_reg[5] <= e2r_pkg::mul30(szcy_reg, sx_reg);
            p_reg[6] <= e2r_pkg::mul30(szcy_reg, cx_reg);
            p_reg[7] <= e2r_pkg::mul30(czsy_reg, sx_reg);

            q_reg[0] <= p_reg[0] + p_reg[1];
            q_reg[1] <= p_reg[2] - p_reg[3];
            q_reg[2] <= p_reg[4] + p_reg[5];
            q_reg[3] <= p_reg[6] - p_reg[7];
        end
    end

    assign q_o = q_reg;

endmodule

FILE: rtl/core/e2r_mat.sv
// ----------------------------------------------------------------------------
// e2r_mat
// Rotation matrix from quaternion: pair products, then sums with output
// rounding and saturation.
// ----------------------------------------------------------------------------
module e2r_mat (
    input  logic          aclk,
    input  logic          ce,
    input  e2r_pkg::val_t q [4],
    output e2r_pkg::coef_t rot_o [9]
);

    // p00 p11 p22 p33 p01 p02 p03 p12 p13 p23
    e2r_pkg::val_t  p_reg [10];
    e2r_pkg::coef_t rot_reg [9];
    e2r_pkg::tval_t p00, p11, p22, p33, p01, p02, p03, p12, p13, p23;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg[0] <= e2r_pkg::mul30(q[0], q[0]);
            p_reg[1] <= e2r_pkg::mul30(q[1], q[1]);
            p_reg[2] <= e2r_pkg::mul30(q[2], q[2]);
            p_reg[3] <= e2r_pkg::mul30(q[3], q[3]);
            p_reg[4] <= e2r_pkg::mul30(q[0], q[1]);
            p_reg[5] <= e2r_pkg::mul30(q[0], q[2]);
            p_reg[6] <= e2r_pkg::mul30(q[0], q[3]);
            p_reg[7] <= e2r_pkg::mul30(q[1], q[2]);
            p_reg[8] <= e2r_pkg::mul30(q[1], q[3]);
            p_reg[9] <= e2r_pkg::mul30(q[2], q[3]);
        end
    end

    assign p00 = e2r_pkg::tval_t'(p_reg[0]);
    assign p11 = e2r_pkg::tval_t'(p_reg[1]);
    assign p22 = e2r_pkg::tval_t'(p_reg[2]);
    assign p33 = e2r_pkg::tval_t'(p_reg[3]);
    assign p01 = e2r_pkg::tval_t'(p_reg[4]);
    assign p02 = e2r_pkg::tval_t'(p_reg[5]);
    assign p03 = e2r_pkg::tval_t'(p_reg[6]);
    assign p12 = e2r_pkg::tval_t'(p_reg[7]);
    assign p13 = e2r_pkg::tval_t'(p_reg[8]);
    assign p23 = e2r_pkg::tval_t'(p_reg[9]);

    always_ff @(posedge aclk) begin
        if (ce) begin
            rot_reg[0] <= e2r_pkg::coef_out(p00 + p11 - p22 - p33);
            rot_reg[1] <= e2r_pkg::coef_out((p12 - p03) <<< 1);
            rot_reg[2] <= e2r_pkg::coef_out((p13 + p02) <<< 1);
            rot_reg[3] <= e2r_pkg::coef_out((p12 + p03) <<< 1);
            rot_reg[4] <= e2r_pkg::coef_out(p00 - p11 + p22 - p33);
            rot_reg[5] <= e2r_pkg::coef_out((p23 - p01) <<< 1);
            rot_reg[6] <= e2r_pkg::coef_out((p13 - p02) <<< 1);
            rot_reg[7] <= e2r_pkg::coef_out((p23 + p01) <<< 1);
            rot_reg[8] <= e2r_pkg::coef_out(p00 - p11 - p22 + p33);
        end
    end

    assign rot_o = rot_reg;

endmodule

FILE: rtl/core/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Pose stream to rigid transform: half-angle CORDIC per axis, z-y-x
// quaternion, 3x3 rotation matrix in Q2.14; translations ride alongside.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Beat contents
//  s_*       in   s_valid / s_ready  angle_x/y/z (Q4.12), move_x/y/z (Q16.16)
//  m_*       out  m_valid / m_ready  rot_00..rot_22 (Q2.14), shift_x/y/z
//
//  One beat in per cycle, one beat out per cycle unless the output stalls; stages:
//  1 fold, 14 CORDIC iterations, 1 sign fix, 3 quaternion, 2 matrix.
//  The whole pipe advances on one enable; it freezes only while the output
//  register holds a beat that is not taken, so s_ready = !m_valid | m_ready.
//  Reset (aresetn low, synchronous) clears the valid bits; data is not reset.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] s_angle_x,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] s_angle_y,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] s_angle_z,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  s_move_x,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  s_move_y,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  s_move_z,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_00,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_01,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_02,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_10,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_11,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_12,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_20,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_21,
    output logic signed [e2r_pkg::COEF_W-1:0] m_rot_22,
    output logic signed [e2r_pkg::MOVE_W-1:0]  m_shift_x,
    output logic signed [e2r_pkg::MOVE_W-1:0]  m_shift_y,
    output logic signed [e2r_pkg::MOVE_W-1:0]  m_shift_z
);

    localparam int LAT = e2r_pkg::LATENCY;

    logic ce;

    // valid bit per stage; last one is the output register's
    logic [LAT-1:0] valid_reg, valid_next;

    // translations delayed to match the datapath
    e2r_pkg::move_t mx_reg [LAT];
    e2r_pkg::move_t my_reg [LAT];
    e2r_pkg::move_t mz_reg [LAT];

    e2r_pkg::val_t  sx, cx, sy, cy, sz, cz;
    e2r_pkg::val_t  q [4];
    e2r_pkg::coef_t rot [9];

    // global advance: hold everything only when the output beat is stuck
    assign ce      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = ce;

    assign valid_next = {valid_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mx_reg[0] <= s_move_x;
            my_reg[0] <= s_move_y;
            mz_reg[0] <= s_move_z;
            for (int i = 1; i < LAT; i++) begin
                mx_reg[i] <= mx_reg[i-1];
                my_reg[i] <= my_reg[i-1];
                mz_reg[i] <= mz_reg[i-1];
            end
        end
    end

    e2r_cordic u_cordic_x (.aclk(aclk), .ce(ce), .angle(s_angle_x), .sin_o(sx), .cos_o(cx));
    e2r_cordic u_cordic_y (.aclk(aclk), .ce(ce), .angle(s_angle_y), .sin_o(sy), .cos_o(cy));
    e2r_cordic u_cordic_z (.aclk(aclk), .ce(ce), .angle(s_angle_z), .sin_o(sz), .cos_o(cz));

    e2r_quat u_quat (
        .aclk (aclk),
        .ce   (ce),
        .sx   (sx),
        .cx   (cx),
        .sy   (sy),
        .cy   (cy),
        .sz   (sz),
        .cz   (cz),
        .q_o  (q)
    );

    e2r_mat u_mat (
        .aclk  (aclk),
        .ce    (ce),
        .q     (q),
        .rot_o (rot)
    );

    assign m_valid   = valid_reg[LAT-1];
    assign m_rot_00  = rot[0];
    assign m_rot_01  = rot[1];
    assign m_rot_02  = rot[2];
    assign m_rot_10  = rot[3];
    assign m_rot_11  = rot[4];
    assign m_rot_12  = rot[5];
    assign m_rot_20  = rot[6];
    assign m_rot_21  = rot[7];
    assign m_rot_22  = rot[8];
    assign m_shift_x = mx_reg[LAT-1];
    assign m_shift_y = my_reg[LAT-1];
    assign m_shift_z = mz_reg[LAT-1];

endmodule

FILE: verif/e2r_transform_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_transform_checker
// Watches both channels of the Euler-to-matrix block, computes the expected
// transform for every accepted pose and compares it with each result beat.
// ----------------------------------------------------------------------------
module e2r_transform_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] s_angle_x,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] s_angle_y,
    input  logic signed [e2r_pkg::ANGLE_W-1:0] s_angle_z,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  s_move_x,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  s_move_y,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  s_move_z,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_00,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_01,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_02,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_10,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_11,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_12,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_20,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_21,
    input  logic signed [e2r_pkg::COEF_W-1:0]  m_rot_22,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  m_shift_x,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  m_shift_y,
    input  logic signed [e2r_pkg::MOVE_W-1:0]  m_shift_z,
    output int                                 fail_count,
    output int                                 pending_count,
    output int                                 checked_count
);
    import e2r_pkg::*;

    typedef struct packed {
        coef_t [8:0] rot;    // rot[0] = T00 ... rot[8] = T22
        move_t       sx;
        move_t       sy;
        move_t       sz;
    } xform_t;

    localparam longint TWO_PI_L  = 64'sd6746518852;
    localparam longint PI_L      = 64'sd3373259426;
    localparam longint HALF_PI_L = 64'sd1686629713;
    localparam longint GAIN_L    = 64'sd652032874;
    localparam longint ARCTAN [0:13] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072
    };

    xform_t expected_xforms[$];

    function automatic longint qmul(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    // half-angle sine/cosine, folded into +-pi/2 then CORDIC
    function automatic void half_sincos(input logic signed [15:0] ang,
                                        output longint s, output longint c);
        longint r, x, y, dx, dy;
        bit     flip;
        r = (longint'(ang) * 131072) % TWO_PI_L;
        flip = 0;
        x = GAIN_L;
        y = 0;
        if (r > PI_L) r -= TWO_PI_L;
        else if (r < -PI_L) r += TWO_PI_L;
        if (r > HALF_PI_L) begin
            r -= PI_L;
            flip = 1;
        end else if (r < -HALF_PI_L) begin
            r += PI_L;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (r >= 0) begin
                x -= dy; y += dx; r -= ARCTAN[i];
            end else begin
                x += dy; y -= dx; r += ARCTAN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic coef_t to_coef(longint t);
        longint v;
        v = (t + 64'sd32768) >>> 16;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return coef_t'(v);
    endfunction

    function automatic xform_t pose_to_xform(logic signed [15:0] ax, ay, az,
                                             move_t mx, my, mz);
        longint sx, cx, sy, cy, sz, cz, czcy, szsy, czsy, szcy;
        longint q0, q1, q2, q3, p00, p11, p22, p33, p01, p02, p03, p12, p13, p23;
        xform_t o;
        half_sincos(ax, sx, cx);
        half_sincos(ay, sy, cy);
        half_sincos(az, sz, cz);
        czcy = qmul(cz, cy); szsy = qmul(sz, sy);
        czsy = qmul(cz, sy); szcy = qmul(sz, cy);
        q0 = qmul(czcy, cx) + qmul(szsy, sx);
        q1 = qmul(czcy, sx) - qmul(szsy, cx);
        q2 = qmul(czsy, cx) + qmul(szcy, sx);
        q3 = qmul(szcy, cx) - qmul(czsy, sx);
        p00 = qmul(q0, q0); p11 = qmul(q1, q1); p22 = qmul(q2, q2); p33 = qmul(q3, q3);
        p01 = qmul(q0, q1); p02 = qmul(q0, q2); p03 = qmul(q0, q3);
        p12 = qmul(q1, q2); p13 = qmul(q1, q3); p23 = qmul(q2, q3);
        o.rot[0] = to_coef(p00 + p11 - p22 - p33);
        o.rot[1] = to_coef(2 * (p12 - p03));
        o.rot[2] = to_coef(2 * (p13 + p02));
        o.rot[3] = to_coef(2 * (p12 + p03));
        o.rot[4] = to_coef(p00 - p11 + p22 - p33);
        o.rot[5] = to_coef(2 * (p23 - p01));
        o.rot[6] = to_coef(2 * (p13 - p02));
        o.rot[7] = to_coef(2 * (p23 + p01));
        o.rot[8] = to_coef(p00 - p11 - p22 + p33);
        o.sx = mx; o.sy = my; o.sz = mz;
        return o;
    endfunction

    initial begin
        fail_count = 0;
        pending_count = 0;
        checked_count = 0;
    end

    always @(posedge aclk) begin
        xform_t got, want;
        if (aresetn && s_valid && s_ready)
            expected_xforms.push_back(pose_to_xform(s_angle_x, s_angle_y, s_angle_z,
                                                    s_move_x, s_move_y, s_move_z));
        if (aresetn && m_valid && m_ready) begin
            got.rot = {m_rot_22, m_rot_21, m_rot_20, m_rot_12, m_rot_11, m_rot_10,
                       m_rot_02, m_rot_01, m_rot_00};
            got.sx = m_shift_x; got.sy = m_shift_y; got.sz = m_shift_z;
            if (expected_xforms.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result beat with no pose pending, at %0t", $realtime);
            end else begin
                want = expected_xforms.pop_front();
                checked_count++;
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("ERROR: transform %0d mismatch", checked_count);
                        for (int k = 0; k < 9; k++)
                            if (got.rot[k] !== want.rot[k])
                                $display("  rot_%0d%0d exp %0d got %0d", k / 3, k % 3,
                                         want.rot[k], got.rot[k]);
                        if (got.sx !== want.sx || got.sy !== want.sy || got.sz !== want.sz)
                            $display("  shift exp %h %h %h got %h %h %h", want.sx,
                                     want.sy, want.sz, got.sx, got.sy, got.sz);
                    end
                end
            end
        end
    end

    always @(posedge aclk) pending_count <= expected_xforms.size();

endmodule

FILE: verif/tb_euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix
// Drives pose beats into the Euler-to-matrix block with random gaps and
// output back-pressure; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix;
    import e2r_pkg::*;

    localparam int N_RANDOM   = 1280;
    localparam int IDLE_LIMIT = 3000;   // cycles with no beat moved on either side

    // angle landmarks in Q4.12 radians
    localparam logic signed [15:0] A_HALF_PI = 16'sd6434;
    localparam logic signed [15:0] A_PI      = 16'sd12868;
    localparam logic signed [15:0] A_TWO_PI  = 16'sd25736;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic signed [ANGLE_W-1:0] s_angle_x, s_angle_y, s_angle_z;
    logic signed [MOVE_W-1:0]  s_move_x, s_move_y, s_move_z;
    logic signed [COEF_W-1:0]  m_rot_00, m_rot_01, m_rot_02, m_rot_10, m_rot_11;
    logic signed [COEF_W-1:0]  m_rot_12, m_rot_20, m_rot_21, m_rot_22;
    logic signed [MOVE_W-1:0]  m_shift_x, m_shift_y, m_shift_z;
    int fail_count, pending_count, checked_count;
    int poses_sent;
    int idle_cycles;
    bit send_gaps;   // gaps on the input side
    bit recv_gaps;   // stalls on the output side

    always #1 aclk = ~aclk;

    euler_to_rotation_matrix DUT (.*);

    e2r_transform_checker u_checker (.*);

    // Send one pose beat; valid stays up until taken.
    task automatic send_pose(logic signed [15:0] ax, ay, az,
                             logic signed [31:0] mx, my, mz);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_angle_x <= ax; s_angle_y <= ay; s_angle_z <= az;
        s_move_x  <= mx; s_move_y  <= my; s_move_z  <= mz;
        do @(posedge aclk); while (!s_ready);
        poses_sent++;
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2 * 25736)) - A_TWO_PI;
            2: return 16'($urandom_range(0, 1000)) - 16'sd500;
            default: return 16'($urandom_range(0, 200)) - 16'sd100
                           + (($urandom_range(0, 1)) ? A_PI : -A_HALF_PI);
        endcase
    endfunction

    // Result side: stall a random number of cycles per beat, sometimes never.
    initial begin
        int wait_n;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            wait_n = recv_gaps ? $urandom_range(0, 9) : 0;
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog: give up when no beat has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] edge_angles [0:9];
        edge_angles = '{16'sd0, 16'sd32767, -16'sd32768, A_HALF_PI, -A_HALF_PI,
                        A_PI, -A_PI, A_TWO_PI, -A_TWO_PI, 16'sd1};
        idle_cycles = 0;
        poses_sent = 0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_angle_x <= '0; s_angle_y <= '0; s_angle_z <= '0;
        s_move_x  <= '0; s_move_y  <= '0; s_move_z  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, landmark angle triples with a different landmark on each axis,
        // all-axes extremes, translation extremes
        send_pose(0, 0, 0, 0, 0, 0);
        for (int k = 1; k < 10; k++)
            send_pose(edge_angles[k], edge_angles[(k + 3) % 10], edge_angles[(k + 6) % 10],
                      32'sh7fffffff, 32'sh80000000, 32'(k));
        send_pose(16'sd32767, 16'sd32767, 16'sd32767, 32'sh80000000, 32'sh7fffffff, -1);
        send_pose(-16'sd32768, -16'sd32768, -16'sd32768, -1, 0, 32'sh55555555);
        send_pose(A_HALF_PI, A_HALF_PI, A_HALF_PI, 32'shaaaaaaaa, 32'sh55555555, 0);
        send_pose(A_PI, 0, 0, 0, 0, 0);
        send_pose(0, A_PI, 0, 0, 0, 0);
        send_pose(0, 0, A_PI, 0, 0, 0);
        send_pose(A_PI + 16'sd1, -A_PI - 16'sd1, A_HALF_PI + 16'sd1, 1, 1, 1);
        send_pose(A_HALF_PI, A_HALF_PI - 16'sd1, -A_HALF_PI, 0, 0, 0);

        // random poses; the pacing mode is drawn anew every hundred beats
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                send_gaps = $urandom_range(0, 2) != 0;
                recv_gaps = $urandom_range(0, 2) != 0;
            end
            send_pose(rand_angle(), rand_angle(), rand_angle(),
                      32'($urandom), 32'($urandom), 32'($urandom));
        end
        s_valid <= 1'b0;

        // drain, then keep watching quietly for stray beats
        while (pending_count != 0 || u_checker.expected_xforms.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);

        $display("Sent %0d poses (landmark and random angles, edge translations),",
                 poses_sent);
        $display("checked %0d transforms under random input gaps and output stalls.",
                 checked_count);
        if (fail_count == 0 && pending_count == 0 && checked_count == poses_sent)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
